// File: src/aapr_pkg.sv
package aapr_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN = 24;
  localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  // cordic datapath width: q30 values with growth headroom
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  localparam logic [1:0] REG_AXIS_X = 2'd0;
  localparam logic [1:0] REG_AXIS_Y = 2'd1;
  localparam logic [1:0] REG_AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [15:0] angle;
    logic               flip;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } item_t;

  // atan(2^-i), 2^31 = pi
  function automatic logic signed [CW-1:0] atan_val(input int i);
    logic signed [CW-1:0] v;
    case (i)
      0: v = 34'sd536870912;
      1: v = 34'sd316933406;
      2: v = 34'sd167458907;
      3: v = 34'sd85004756;
      4: v = 34'sd42667331;
      5: v = 34'sd21354465;
      6: v = 34'sd10680862;
      7: v = 34'sd5340245;
      8: v = 34'sd2670163;
      9: v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: src/aapr_if.sv
interface aapr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source(output valid, angle, point_x, point_y, point_z, input ready);
  modport sink(input valid, angle, point_x, point_y, point_z, output ready);
endinterface

interface aapr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rotated_x;
  logic signed [31:0] rotated_y;
  logic signed [31:0] rotated_z;
  logic               saturated;
  modport source(output valid, rotated_x, rotated_y, rotated_z, saturated, input ready);
  modport sink(input valid, rotated_x, rotated_y, rotated_z, saturated, output ready);
endinterface

// File: src/axis_angle_point_rotator.sv
// Rotates each point about the configured axis by the item's angle, one item per
// clock cycle sustained while the output register is not stalled; an item passes
// through the pipelined cordic, with one stage per step, and then through five
// multiply and sum stages. A four-item queue sits between the input side and the
// pipeline, and the output register stalls the whole pipeline while its item waits.
// The axis registers reset to the y axis, are clamped to +-1.0 on write and must only
// be written while no item is in flight.
module axis_angle_point_rotator
  import aapr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  aapr_in_if.sink     din,
  aapr_out_if.source  dout,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data
);

  logic signed [15:0] axis [3];
  logic signed [15:0] wr_val;
  logic               push;
  item_t              push_item;
  logic               push_ready;
  logic               pop;
  item_t              head;
  logic               head_valid;

  always_comb begin
    if ($signed(wr_data) > ONE_Q14) wr_val = ONE_Q14;
    else if ($signed(wr_data) < -ONE_Q14) wr_val = -ONE_Q14;
    else wr_val = $signed(wr_data);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis[0] <= '0;
      axis[1] <= ONE_Q14;
      axis[2] <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_AXIS_X: axis[0] <= wr_val;
        REG_AXIS_Y: axis[1] <= wr_val;
        REG_AXIS_Z: axis[2] <= wr_val;
        default: ;
      endcase
    end
  end

  aapr_front u_front (
    .din        (din),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  aapr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  aapr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .axis       (axis),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .dout       (dout)
  );

endmodule

// File: src/aapr_front.sv
module aapr_front
  import aapr_pkg::*;
(
  aapr_in_if.sink     din,
  output logic        push,
  output item_t       push_item,
  input  logic        push_ready
);

  // fold the angle into the right half plane, flip the result sign
  always_comb begin
    push_item.px = din.point_x;
    push_item.py = din.point_y;
    push_item.pz = din.point_z;
    if (din.angle > 16'sd16384) begin
      push_item.angle = din.angle - 16'sd32767 - 16'sd1;
      push_item.flip  = 1'b1;
    end else if (din.angle < -16'sd16384) begin
      push_item.angle = din.angle + 16'sd32767 + 16'sd1;
      push_item.flip  = 1'b1;
    end else begin
      push_item.angle = din.angle;
      push_item.flip  = 1'b0;
    end
  end

  assign push      = din.valid & push_ready;
  assign din.ready = push_ready;

endmodule

// File: src/aapr_queue.sv
module aapr_queue
  import aapr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  push_ready,
  input  logic  pop,
  output item_t head,
  output logic  head_valid
);

  item_t          mem [QDEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;
  logic [QAW:0]   count;
  logic           do_pop;

  assign push_ready = (count != (QAW+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rp];
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (do_pop) rp <= rp + 1'b1;
      count <= count + (QAW+1)'(push) - (QAW+1)'(do_pop);
    end
  end

endmodule

// File: src/aapr_back.sv
module aapr_back
  import aapr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic signed [15:0] axis [3],
  input  item_t              head,
  input  logic               head_valid,
  output logic               pop,
  aapr_out_if.source         dout
);

  logic adv;

  logic                 cv   [NSTEP+1];
  logic signed [CW-1:0] cx   [NSTEP+1];
  logic signed [CW-1:0] cy   [NSTEP+1];
  logic signed [CW-1:0] cz   [NSTEP+1];
  logic                 cf   [NSTEP+1];
  logic signed [31:0]   cp3  [NSTEP+1][3];

  logic               va;
  logic signed [15:0] sa;
  logic signed [15:0] ca;
  logic signed [31:0] pa  [3];
  logic signed [47:0] m1  [3];
  logic signed [47:0] m2  [3];
  logic signed [47:0] m3  [3];

  logic               vb;
  logic signed [15:0] sb;
  logic signed [15:0] cb;
  logic signed [31:0] pb  [3];
  logic signed [48:0] crb [3];
  logic signed [49:0] dotb;

  logic               vc;
  logic signed [15:0] cc;
  logic signed [65:0] adf [3];
  logic signed [64:0] scc [3];
  logic signed [47:0] cpc [3];

  logic               vd;
  logic signed [68:0] t2  [3];
  logic signed [64:0] scd [3];
  logic signed [47:0] cpd [3];

  logic signed [CW-1:0] xf;
  logic signed [CW-1:0] yf;
  logic signed [17:0]   c_raw;
  logic signed [17:0]   s_raw;
  logic signed [15:0]   c_cl;
  logic signed [15:0]   s_cl;
  logic signed [16:0]   omc;
  logic signed [31:0]   res [3];
  logic                 sat_any;

  assign adv = ~dout.valid | dout.ready;
  assign pop = adv;

  always_ff @(posedge clk) begin
    if (adv) begin
      cx[0] <= CORDIC_X0;
      cy[0] <= '0;
      cz[0] <= {{(CW-32){head.angle[15]}}, head.angle, 16'h0000};
      cf[0] <= head.flip;
      cp3[0][0] <= head.px;
      cp3[0][1] <= head.py;
      cp3[0][2] <= head.pz;
    end
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        if (cz[i] >= 0) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - atan_val(i);
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + atan_val(i);
        end
        cf[i+1]  <= cf[i];
        cp3[i+1] <= cp3[i];
      end
    end
  end

  // apply the flip, round to q14 and clamp to unit range
  always_comb begin
    xf    = cf[NSTEP] ? -cx[NSTEP] : cx[NSTEP];
    yf    = cf[NSTEP] ? -cy[NSTEP] : cy[NSTEP];
    c_raw = 18'((xf + CW'(32768)) >>> 16);
    s_raw = 18'((yf + CW'(32768)) >>> 16);
    if (c_raw > 18'sd16384) c_cl = ONE_Q14;
    else if (c_raw < -18'sd16384) c_cl = -ONE_Q14;
    else c_cl = 16'(c_raw);
    if (s_raw > 18'sd16384) s_cl = ONE_Q14;
    else if (s_raw < -18'sd16384) s_cl = -ONE_Q14;
    else s_cl = 16'(s_raw);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa <= s_cl;
      ca <= c_cl;
      for (int k = 0; k < 3; k++) begin
        pa[k] <= cp3[NSTEP][k];
        m1[k] <= axis[(k+1)%3] * cp3[NSTEP][(k+2)%3];
        m2[k] <= axis[(k+2)%3] * cp3[NSTEP][(k+1)%3];
        m3[k] <= axis[k] * cp3[NSTEP][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb   <= sa;
      cb   <= ca;
      pb   <= pa;
      dotb <= 50'(m3[0]) + 50'(m3[1]) + 50'(m3[2]);
      for (int k = 0; k < 3; k++) begin
        crb[k] <= 49'(m1[k]) - 49'(m2[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cc <= cb;
      for (int k = 0; k < 3; k++) begin
        adf[k] <= axis[k] * dotb;
        scc[k] <= sb * crb[k];
        cpc[k] <= cb * pb[k];
      end
    end
  end

  assign omc = 17'sd16384 - 17'(cc);

  always_ff @(posedge clk) begin
    if (adv) begin
      scd <= scc;
      cpd <= cpc;
      for (int k = 0; k < 3; k++) begin
        t2[k] <= omc * 52'((adf[k] + 66'sd8192) >>> 14);
      end
    end
  end

  always_comb begin
    logic signed [71:0] sum;
    logic signed [43:0] r;
    sat_any = 1'b0;
    for (int k = 0; k < 3; k++) begin
      sum = 72'(scd[k]) + 72'(t2[k]) + (72'(cpd[k]) <<< 14);
      r   = 44'((sum + (72'sd1 <<< 27)) >>> 28);
      if (r > 44'sd2147483647) begin
        res[k]  = 32'sh7fffffff;
        sat_any = 1'b1;
      end else if (r < -44'sd2147483648) begin
        res[k]  = 32'sh80000000;
        sat_any = 1'b1;
      end else begin
        res[k] = 32'(r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout.rotated_x <= res[0];
      dout.rotated_y <= res[1];
      dout.rotated_z <= res[2];
      dout.saturated <= sat_any;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NSTEP; i++) cv[i] <= 1'b0;
      va         <= 1'b0;
      vb         <= 1'b0;
      vc         <= 1'b0;
      vd         <= 1'b0;
      dout.valid <= 1'b0;
    end else if (adv) begin
      cv[0] <= head_valid;
      for (int i = 0; i < NSTEP; i++) cv[i+1] <= cv[i];
      va         <= cv[NSTEP];
      vb         <= va;
      vc         <= vb;
      vd         <= vc;
      dout.valid <= vd;
    end
  end

  a_resid: assert property (@(posedge clk) disable iff (rst)
    cv[NSTEP] |-> (cz[NSTEP] <= atan_val(NSTEP-1) + CW'(NSTEP)) &&
                  (cz[NSTEP] >= -(atan_val(NSTEP-1) + CW'(NSTEP))))
    else $error("cordic residual angle too large");

  a_unit: assert property (@(posedge clk) disable iff (rst)
    va |-> (ca <= ONE_Q14) && (ca >= -ONE_Q14) && (sa <= ONE_Q14) && (sa >= -ONE_Q14))
    else $error("sine or cosine outside unit range");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.saturated) |->
      (dout.rotated_x == 32'sh7fffffff || dout.rotated_x == 32'sh80000000 ||
       dout.rotated_y == 32'sh7fffffff || dout.rotated_y == 32'sh80000000 ||
       dout.rotated_z == 32'sh7fffffff || dout.rotated_z == 32'sh80000000))
    else $error("saturation flag without clamped coordinate");

endmodule

// File: verif/tb_axis_angle_point_rotator.sv
`default_nettype none

module tb_axis_angle_point_rotator;
  timeunit 1ns;
  timeprecision 1ps;

  import aapr_pkg::*;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sat;
  } rotated_t;

  localparam longint ATAN_Q31 [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = REG_AXIS_X;
  logic [15:0] wr_data = '0;

  aapr_in_if  din();
  aapr_out_if dout();

  axis_angle_point_rotator u_dut (
    .clk(clk),
    .rst(rst),
    .din(din.sink),
    .dout(dout.source),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always #10 clk = ~clk;

  logic signed [15:0] axis_reg [3];
  rotated_t expected_q [$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int saturated_seen = 0;
  bit quiet = 1'b0;
  int hold_cycles = 0;
  int stall_left = 0;

  initial begin
    din.valid = 1'b0;
    din.angle = '0;
    din.point_x = '0;
    din.point_y = '0;
    din.point_z = '0;
    dout.ready = 1'b0;
  end

  function automatic longint clamp_q14(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic rotated_t rotate_point(logic signed [15:0] ang, logic signed [31:0] px,
                                            logic signed [31:0] py, logic signed [31:0] pz);
    longint a, x, y, z, dx, dy, s, c, dot, ad, sum, r;
    longint av [3];
    longint pv [3];
    longint cr [3];
    longint rv [3];
    bit flip;
    rotated_t res;
    a = ang;
    flip = 1'b0;
    if (a > 16384) begin
      a -= 32768;
      flip = 1'b1;
    end else if (a < -16384) begin
      a += 32768;
      flip = 1'b1;
    end
    x = 652032874;
    y = 0;
    z = a * 65536;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_Q31[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_Q31[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clamp_q14((x + 32768) >>> 16);
    s = clamp_q14((y + 32768) >>> 16);
    for (int k = 0; k < 3; k++) av[k] = clamp_q14(longint'(axis_reg[k]));
    pv[0] = px;
    pv[1] = py;
    pv[2] = pz;
    cr[0] = av[1] * pv[2] - av[2] * pv[1];
    cr[1] = av[2] * pv[0] - av[0] * pv[2];
    cr[2] = av[0] * pv[1] - av[1] * pv[0];
    dot = av[0] * pv[0] + av[1] * pv[1] + av[2] * pv[2];
    res.sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      ad = (av[k] * dot + 8192) >>> 14;
      sum = s * cr[k] + (16384 - c) * ad + c * pv[k] * 16384;
      r = (sum + (longint'(1) << 27)) >>> 28;
      if (r > 64'sd2147483647) begin
        r = 64'sd2147483647;
        res.sat = 1'b1;
      end else if (r < -64'sd2147483648) begin
        r = -64'sd2147483648;
        res.sat = 1'b1;
      end
      rv[k] = r;
    end
    res.x = rv[0][31:0];
    res.y = rv[1][31:0];
    res.z = rv[2][31:0];
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    errors++;
    $display("mismatch %s at result %0d: got %0d expected %0d", field, results_seen, got, want);
  endtask

  // output checker
  always @(posedge clk) begin
    rotated_t e;
    if (!rst && dout.valid && dout.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected item", dout.rotated_x, 0);
      end else begin
        e = expected_q.pop_front();
        if (dout.rotated_x !== e.x) report_mismatch("rotated_x", dout.rotated_x, e.x);
        if (dout.rotated_y !== e.y) report_mismatch("rotated_y", dout.rotated_y, e.y);
        if (dout.rotated_z !== e.z) report_mismatch("rotated_z", dout.rotated_z, e.z);
        if (dout.saturated !== e.sat) report_mismatch("saturated", dout.saturated, e.sat);
        if (e.sat) saturated_seen++;
      end
      results_seen++;
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      dout.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (stall_left > 0) begin
      dout.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      dout.ready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      dout.ready <= 1'b1;
    end
  end

  task automatic send_item(logic signed [15:0] ang, logic signed [31:0] px,
                           logic signed [31:0] py, logic signed [31:0] pz);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      din.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    din.valid <= 1'b1;
    din.angle <= ang;
    din.point_x <= px;
    din.point_y <= py;
    din.point_z <= pz;
    @(posedge clk iff din.ready);
    expected_q.push_back(rotate_point(ang, px, py, pz));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    din.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_axis(logic [1:0] idx, logic [15:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    if (idx == REG_AXIS_X) axis_reg[0] = val;
    else if (idx == REG_AXIS_Y) axis_reg[1] = val;
    else if (idx == REG_AXIS_Z) axis_reg[2] = val;
    @(negedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 2097152)) - 32'sd1048576;
      2: return $signed($urandom_range(0, 33554432)) - 32'sd16777216;
      default: return $signed($urandom_range(0, 1310720)) - 32'sd655360;
    endcase
  endfunction

  function automatic logic [15:0] rand_axis_value();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'd0;
      3: return $urandom;
      default: return $signed($urandom_range(0, 32768)) - 16'sd16384;
    endcase
  endfunction

  task automatic random_items(int n);
    repeat (n) send_item($urandom, rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic test_directed;
    logic signed [15:0] angs [12] = '{0, 1, -1, 16384, -16384, 16383, 16385, -16385,
                                      -32768, 32767, 8192, -8192};
    foreach (angs[i]) send_item(angs[i], 32'sd65536, 32'sd131072, -32'sd196608);
    send_item(16'sd8192, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_item(-16'sd8192, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_item(-16'sd32768, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    send_item(16'sd0, 32'sh7fffffff, 32'sh80000000, 32'sd0);
    send_item(16'sd16384, 32'hffffffff, 32'sd1, 32'hffffffff);
    drain();
    // non-unit and out of range axis values
    write_axis(REG_AXIS_X, 16'h7fff);
    write_axis(REG_AXIS_Y, 16'h8000);
    write_axis(REG_AXIS_Z, 16'sd16384);
    write_axis(2'd3, 16'h1234);
    send_item(16'sd5000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send_item(-16'sd32768, 32'sh12345678, 32'sh80000000, 32'sh7fffffff);
    send_item(16'sd20000, 32'sh55555555, 32'shaaaaaaaa, 32'sd65536);
    drain();
  endtask

  task automatic test_axis_settings;
    logic [15:0] settings [6][3] = '{
      '{16'sd16384, 16'sd0, 16'sd0}, '{16'sd0, 16'sd0, 16'sd16384},
      '{-16'sd16384, 16'sd0, 16'sd0}, '{16'sd9459, 16'sd9459, 16'sd9459},
      '{16'sd0, -16'sd16384, 16'sd0}, '{16'sd1000, -16'sd200, 16'sd0}};
    foreach (settings[i]) begin
      write_axis(REG_AXIS_X, settings[i][0]);
      write_axis(REG_AXIS_Y, settings[i][1]);
      write_axis(REG_AXIS_Z, settings[i][2]);
      random_items(30);
      drain();
    end
  endtask

  task automatic test_random_axes;
    repeat (8) begin
      write_axis(REG_AXIS_X, rand_axis_value());
      write_axis(REG_AXIS_Y, rand_axis_value());
      write_axis(REG_AXIS_Z, rand_axis_value());
      random_items(25);
      drain();
    end
  endtask

  task automatic test_backpressure;
    hold_cycles = 80;
    random_items(30);
    drain();
  endtask

  task automatic test_pause_then_stream;
    random_items(10);
    drain();
    random_items(20);
    drain();
  endtask

  task automatic test_full_rate;
    quiet = 1'b1;
    random_items(90);
    drain();
  endtask

  initial begin
    axis_reg[0] = 16'sd0;
    axis_reg[1] = 16'sd16384;
    axis_reg[2] = 16'sd0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_axis_settings();
    test_random_axes();
    test_backpressure();
    test_pause_then_stream();
    test_full_rate();
    $display("sent %0d points, checked %0d rotated points, %0d of them clamped",
             items_sent, results_seen, saturated_seen);
    $display("axis settings covered unit, negative, non-unit, clamped and ignored writes");
    if (errors == 0) begin
      $display("tb_axis_angle_point_rotator: PASS");
    end else begin
      $display("tb_axis_angle_point_rotator: FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout waiting for rotated points");
    $display("tb_axis_angle_point_rotator: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
